// ===== rtl/pin_proxy_debounce_hold_off_macros.svh =====
// assertion helpers shared by the checker
`ifndef PIN_PROXY_DEBOUNCE_HOLD_OFF_MACROS_SVH
`define PIN_PROXY_DEBOUNCE_HOLD_OFF_MACROS_SVH

// same-cycle implication, off while in reset
`define PDH_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pdh: same-cycle check failed");

// next-cycle implication, off while in reset
`define PDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pdh: next-cycle check failed");

// next-cycle implication that also runs through reset
`define PDH_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pdh: reset check failed");

`endif

// ===== rtl/pdh_pkg.sv =====
package pdh_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_ACTIVATE   = 2'd1;
    localparam logic [1:0] CMD_DEACTIVATE = 2'd2;

    localparam logic [1:0] CFG_DEBOUNCE_ON = 2'd0;
    localparam logic [1:0] CFG_HOLD_OFF    = 2'd1;
    localparam logic [1:0] CFG_ON_LEVEL    = 2'd2;
    localparam logic [1:0] CFG_INVERT      = 2'd3;

    typedef logic [TIMER_WIDTH-1:0] t_timer;

    typedef struct packed {
        logic [1:0] command;
        logic       pin_level;
    } t_in_item;

    typedef struct packed {
        logic drive_enable;
        logic drive_level;
        logic notify_valid;
        logic notify_on;
    } t_out_item;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_on_ms;
        logic [CFG_WIDTH-1:0] hold_off_ms;
        logic                 on_level;
        logic                 invert_output;
    } t_cfg;

endpackage

// ===== rtl/pdh_in_if.sv =====
interface pdh_in_if;
    logic               valid;
    logic               ready;
    pdh_pkg::t_in_item  item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/pdh_out_if.sv =====
interface pdh_out_if;
    logic               valid;
    logic               ready;
    pdh_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/pdh_cfg_if.sv =====
interface pdh_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     index;
    logic [pdh_pkg::CFG_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pdh_cfg_regs.sv =====
module pdh_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pdh_cfg_if.sink       i_cfg,
    output pdh_pkg::t_cfg o_cfg
);
    import pdh_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_on_ms <= '0;
            r_cfg.hold_off_ms    <= '0;
            r_cfg.on_level       <= 1'b1;
            r_cfg.invert_output  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEBOUNCE_ON: r_cfg.debounce_on_ms <= i_cfg.data;
                CFG_HOLD_OFF:    r_cfg.hold_off_ms    <= i_cfg.data;
                CFG_ON_LEVEL:    r_cfg.on_level       <= i_cfg.data[0];
                CFG_INVERT:      r_cfg.invert_output  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/pdh_core.sv =====
module pdh_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdh_pkg::t_cfg      i_cfg,
    input  logic               i_step,
    input  pdh_pkg::t_in_item  i_item,
    output pdh_pkg::t_out_item o_result
);
    import pdh_pkg::*;

    logic   r_last_known, n_last_known;
    logic   r_last_level, n_last_level;
    logic   r_out_known, n_out_known;
    logic   r_out_level, n_out_level;
    logic   r_on_pending, n_on_pending;
    logic   r_holding, n_holding;
    t_timer r_deb_el, n_deb_el;
    t_timer r_hold_el, n_hold_el;
    logic   r_suspended, n_suspended;

    logic   pass_en;
    logic   pass_lvl;
    logic   pass_out;
    logic   note_valid;
    logic   note_on;
    logic   out_means_on;
    logic   changed;
    logic   drive;

    assign out_means_on = r_out_known &&
                          ((r_out_level ^ i_cfg.invert_output) == i_cfg.on_level);
    assign changed  = !r_last_known || (i_item.pin_level != r_last_level);

    // next state
    always_comb begin
        n_last_known = r_last_known;
        n_last_level = r_last_level;
        n_out_known  = r_out_known;
        n_out_level  = r_out_level;
        n_on_pending = r_on_pending;
        n_holding    = r_holding;
        n_deb_el     = r_deb_el;
        n_hold_el    = r_hold_el;
        n_suspended  = r_suspended;
        pass_en      = 1'b0;
        pass_lvl     = 1'b0;
        pass_out     = 1'b0;
        note_valid   = 1'b0;
        note_on      = 1'b0;
        case (i_item.command)
            CMD_TICK: begin
                // elapsed counters saturate
                n_deb_el  = (r_deb_el == '1) ? r_deb_el : r_deb_el + 1'b1;
                n_hold_el = (r_hold_el == '1) ? r_hold_el : r_hold_el + 1'b1;
                if (changed) begin
                    n_last_known = 1'b1;
                    n_last_level = i_item.pin_level;
                    if (i_item.pin_level == i_cfg.on_level) begin
                        if (i_cfg.debounce_on_ms != '0) begin
                            n_deb_el     = '0;
                            n_on_pending = 1'b1;
                        end else if (r_holding) begin
                            n_on_pending = 1'b1;
                        end
                        if (!n_on_pending) begin
                            pass_en  = 1'b1;
                            pass_lvl = i_item.pin_level;
                        end
                    end else begin
                        if (i_cfg.hold_off_ms != '0 && r_out_known) begin
                            n_holding = 1'b1;
                            n_hold_el = '0;
                        end
                        n_on_pending = 1'b0;
                        pass_en      = 1'b1;
                        pass_lvl     = i_item.pin_level;
                    end
                end
                if (n_holding && CMP_WIDTH'(n_hold_el) >= CMP_WIDTH'(i_cfg.hold_off_ms)) begin
                    n_holding = 1'b0;
                end
                // a pending on never coincides with a pass from a level change
                if (n_on_pending && !n_holding &&
                    CMP_WIDTH'(n_deb_el) >= CMP_WIDTH'(i_cfg.debounce_on_ms)) begin
                    pass_en      = 1'b1;
                    pass_lvl     = i_cfg.on_level;
                    n_on_pending = 1'b0;
                end
                pass_out = pass_lvl ^ i_cfg.invert_output;
                if (pass_en && (!r_out_known || r_out_level != pass_out)) begin
                    n_out_known = 1'b1;
                    n_out_level = pass_out;
                    if (!r_suspended) begin
                        note_valid = 1'b1;
                        note_on    = (pass_lvl == i_cfg.on_level);
                    end
                end
            end
            CMD_ACTIVATE: begin
                if (r_suspended) begin
                    n_suspended = 1'b0;
                    if (out_means_on) begin
                        note_valid = 1'b1;
                        note_on    = 1'b1;
                    end
                end
            end
            CMD_DEACTIVATE: begin
                if (!r_suspended) begin
                    n_suspended = 1'b1;
                    if (out_means_on) begin
                        note_valid = 1'b1;
                        note_on    = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign drive                 = !n_suspended && n_out_known;
    assign o_result.drive_enable = drive;
    assign o_result.drive_level  = drive & n_out_level;
    assign o_result.notify_valid = note_valid;
    assign o_result.notify_on    = note_valid & note_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_known <= 1'b0;
            r_last_level <= 1'b0;
            r_out_known  <= 1'b0;
            r_out_level  <= 1'b0;
            r_on_pending <= 1'b0;
            r_holding    <= 1'b0;
            r_deb_el     <= '0;
            r_hold_el    <= '0;
            r_suspended  <= 1'b1;
        end else if (i_step) begin
            r_last_known <= n_last_known;
            r_last_level <= n_last_level;
            r_out_known  <= n_out_known;
            r_out_level  <= n_out_level;
            r_on_pending <= n_on_pending;
            r_holding    <= n_holding;
            r_deb_el     <= n_deb_el;
            r_hold_el    <= n_hold_el;
            r_suspended  <= n_suspended;
        end
    end

endmodule

// ===== rtl/pin_proxy_debounce_hold_off.sv =====
// o_result.valid rises once an accepted request has passed the input register and the result register
// throughput: one request per cycle while the result is taken, input register feeds state logic and result register
// i_sample.ready falls only while both the input and result registers hold and
// the result is not being taken
// reset (i_rst_n low, synchronous): pipeline empty, output never driven, proxy suspended,
// timers zero, registers at their defaults
module pin_proxy_debounce_hold_off (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pdh_cfg_if.sink   i_cfg,
    pdh_in_if.sink    i_sample,
    pdh_out_if.source o_result
);
    import pdh_pkg::*;

    t_cfg      cfg;
    t_out_item result;
    logic      advance;
    logic      step;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign advance        = !r_out_valid || o_result.ready;
    assign step           = r_s1_valid && advance;
    assign i_sample.ready = !r_s1_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.item  = r_out_item;

    pdh_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pdh_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_item   (r_s1_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_s1_valid <= i_sample.valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_s1_item <= i_sample.item;
        end
        if (step) begin
            r_out_item <= result;
        end
    end

endmodule

// ===== rtl/pdh_checker.sv =====
`include "pin_proxy_debounce_hold_off_macros.svh"

module pdh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input pdh_pkg::t_out_item i_out_item
);
    import pdh_pkg::*;

    // a stalled result stays put
    `PDH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_out_item))

    // input side only backs up behind a stalled result
    `PDH_ASSERT(a_in_stall, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

    // an on notification always comes with the pin driven
    `PDH_ASSERT(a_on_driven, i_clk, i_rst_n,
                i_out_valid && i_out_item.notify_valid && i_out_item.notify_on,
                i_out_item.drive_enable)

    // reset empties the result register
    `PDH_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind pin_proxy_debounce_hold_off pdh_checker u_pdh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_item  (o_result.item)
);

// ===== tb/sv/pin_proxy_monitor.sv =====
`timescale 1ns / 1ps

module pin_proxy_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    pdh_cfg_if   cfg_ch,
    pdh_in_if    req_ch,
    pdh_out_if   res_ch,
    output int   o_faults,
    output int   o_pending,
    output int   o_checked,
    output int   o_notes
);
    import pdh_pkg::*;

    localparam logic [1:0] LVL_UNKNOWN = 2'd2;

    // own copy of the registers and of the proxy state
    t_cfg       regs;
    logic [1:0] seen_lvl;
    logic [1:0] out_lvl;
    logic       on_wait;
    logic       holding;
    logic       parked;
    t_timer     deb_cnt;
    t_timer     hold_cnt;
    logic       note_v;
    logic       note_on;

    t_out_item  outputs_q[$];
    t_out_item  want;
    t_out_item  got;
    int         faults;
    int         checked;
    int         notes;

    function automatic void raise_note(input logic on);
        note_v  = 1'b1;
        note_on = on;
    endfunction

    function automatic void pass_qualified(input logic lvl);
        logic [1:0] drv;
        drv = {1'b0, lvl ^ regs.invert_output};
        if (out_lvl != drv) begin
            out_lvl = drv;
            // while suspended the level is only recorded
            if (!parked)
                raise_note(lvl == regs.on_level);
        end
    endfunction

    function automatic void level_moved(input logic lvl);
        if (lvl == regs.on_level) begin
            if (regs.debounce_on_ms != '0) begin
                deb_cnt = '0;
                on_wait = 1'b1;
            end else if (holding) begin
                on_wait = 1'b1;
            end
            if (!on_wait)
                pass_qualified(lvl);
        end else begin
            if (regs.hold_off_ms != '0 && out_lvl != LVL_UNKNOWN) begin
                holding  = 1'b1;
                hold_cnt = '0;
            end
            on_wait = 1'b0;
            pass_qualified(lvl);
        end
    endfunction

    function automatic logic out_is_on();
        if (out_lvl == LVL_UNKNOWN)
            return 1'b0;
        return (out_lvl[0] ^ regs.invert_output) == regs.on_level;
    endfunction

    function automatic t_out_item proxy_step(input t_in_item req);
        t_out_item res;
        note_v  = 1'b0;
        note_on = 1'b0;
        case (req.command)
            CMD_TICK: begin
                // elapsed counters stick at all ones
                if (deb_cnt != '1)
                    deb_cnt = deb_cnt + 1'b1;
                if (hold_cnt != '1)
                    hold_cnt = hold_cnt + 1'b1;
                if ({1'b0, req.pin_level} != seen_lvl) begin
                    level_moved(req.pin_level);
                    seen_lvl = {1'b0, req.pin_level};
                end
                if (holding && hold_cnt >= regs.hold_off_ms)
                    holding = 1'b0;
                if (on_wait && !holding && deb_cnt >= regs.debounce_on_ms) begin
                    pass_qualified(regs.on_level);
                    on_wait = 1'b0;
                end
            end
            CMD_ACTIVATE: begin
                if (parked) begin
                    parked = 1'b0;
                    if (out_is_on())
                        raise_note(1'b1);
                end
            end
            CMD_DEACTIVATE: begin
                if (!parked) begin
                    parked = 1'b1;
                    if (out_is_on())
                        raise_note(1'b0);
                end
            end
            default: ;
        endcase
        res.drive_enable = !parked && out_lvl != LVL_UNKNOWN;
        res.drive_level  = res.drive_enable & out_lvl[0];
        res.notify_valid = note_v;
        res.notify_on    = note_v & note_on;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.debounce_on_ms = '0;
            regs.hold_off_ms    = '0;
            regs.on_level       = 1'b1;
            regs.invert_output  = 1'b0;
            seen_lvl = LVL_UNKNOWN;
            out_lvl  = LVL_UNKNOWN;
            on_wait  = 1'b0;
            holding  = 1'b0;
            parked   = 1'b1;
            deb_cnt  = '0;
            hold_cnt = '0;
            outputs_q.delete();
        end else begin
            // results leave only after passing the input and result registers, so check before queueing
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.item;
                if (outputs_q.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: result with nothing outstanding: %s %b/%b notify %b/%b",
                                 $time, "drive", got.drive_enable, got.drive_level,
                                 got.notify_valid, got.notify_on);
                end else begin
                    want = outputs_q.pop_front();
                    checked++;
                    if (want.notify_valid)
                        notes++;
                    if (got.drive_enable !== want.drive_enable ||
                        got.drive_level  !== want.drive_level  ||
                        got.notify_valid !== want.notify_valid ||
                        got.notify_on    !== want.notify_on) begin
                        faults++;
                        if (faults <= 10)
                            $display({"%0t: result %0d expected drive %b/%b notify %b/%b, ",
                                      "got %b/%b notify %b/%b"},
                                     $time, checked, want.drive_enable, want.drive_level,
                                     want.notify_valid, want.notify_on, got.drive_enable,
                                     got.drive_level, got.notify_valid, got.notify_on);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_DEBOUNCE_ON: regs.debounce_on_ms = cfg_ch.data;
                    CFG_HOLD_OFF:    regs.hold_off_ms    = cfg_ch.data;
                    CFG_ON_LEVEL:    regs.on_level       = cfg_ch.data[0];
                    CFG_INVERT:      regs.invert_output  = cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
                outputs_q.insert(outputs_q.size(), proxy_step(req_ch.item));
        end
        o_faults  <= faults;
        o_pending <= outputs_q.size();
        o_checked <= checked;
        o_notes   <= notes;
    end

endmodule

// ===== tb/sv/tb_pin_proxy_debounce_hold_off.sv =====
`timescale 1ns / 1ps

module tb_pin_proxy_debounce_hold_off;
    import pdh_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         PHASES     = 12;
    localparam int         PHASE_REQS = 128;

    logic i_clk;
    logic i_rst_n;

    pdh_cfg_if cfg_ch ();
    pdh_in_if  req_ch ();
    pdh_out_if res_ch ();

    int faults;
    int pending;
    int checked;
    int notes;

    bit calm;
    bit sending;
    int n_req;
    int n_settings;

    pin_proxy_debounce_hold_off DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_sample (req_ch),
        .o_result (res_ch)
    );

    pin_proxy_monitor monitor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cfg_ch    (cfg_ch),
        .req_ch    (req_ch),
        .res_ch    (res_ch),
        .o_faults  (faults),
        .o_pending (pending),
        .o_checked (checked),
        .o_notes   (notes)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int unsigned run;
        int unsigned stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (calm) begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run   = $urandom_range(1, 12);
                stall = gap_len();
                res_ch.ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                if (stall > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // the monitor's count is registered, so it lags behind the queue
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic park_sender();
        if (sending) begin
            req_ch.valid <= 1'b0;
            sending = 1'b0;
        end
    endtask

    task automatic put_req(input logic [1:0] cmd, input logic lvl);
        t_in_item    req;
        int unsigned gap;
        bit          drain;
        req.command   = cmd;
        req.pin_level = lvl;
        req_ch.valid <= 1'b1;
        req_ch.item  <= req;
        sending = 1'b1;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        n_req++;
        gap   = gap_len();
        drain = !calm && $urandom_range(0, 199) == 0;
        if (gap > 0 || drain) begin
            req_ch.valid <= 1'b0;
            sending = 1'b0;
            repeat (gap) @(posedge i_clk);
            if (drain)
                wait_drained();
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
    endtask

    // registers only change with nothing in flight
    task automatic set_regs(input logic [CFG_WIDTH-1:0] deb, input logic [CFG_WIDTH-1:0] hold,
                            input logic onl, input logic inv);
        park_sender();
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_DEBOUNCE_ON, deb);
        write_reg(CFG_HOLD_OFF, hold);
        write_reg(CFG_ON_LEVEL, {{(CFG_WIDTH-1){1'b0}}, onl});
        write_reg(CFG_INVERT, {{(CFG_WIDTH-1){1'b0}}, inv});
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    // bouncing pin runs with commands mixed in
    task automatic pin_traffic(input int unsigned deb, input int unsigned hold,
                               input int unsigned budget);
        logic        lvl;
        int unsigned span;
        int unsigned run;
        int unsigned sel;
        int unsigned done;
        lvl  = $urandom_range(0, 1);
        span = deb + hold + 3;
        if (span > 16)
            span = 16;
        done = 0;
        while (done < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                if ($urandom_range(0, 3) != 0)
                    lvl = ~lvl;
                run = $urandom_range(1, span);
                repeat (run) begin
                    put_req(CMD_TICK, ($urandom_range(0, 19) == 0) ? ~lvl : lvl);
                    done++;
                end
            end else if (sel < 91) begin
                put_req(CMD_ACTIVATE, $urandom_range(0, 1));
                done++;
            end else if (sel < 97) begin
                put_req(CMD_DEACTIVATE, $urandom_range(0, 1));
                done++;
            end else begin
                put_req(CMD_UNUSED, $urandom_range(0, 1));
                done++;
            end
        end
    endtask

    initial begin
        int unsigned deb_set[PHASES];
        int unsigned hold_set[PHASES];
        int unsigned deb;
        int unsigned hold;
        deb_set  = '{0, 65535, 1, 3, 0, 5, 2, 0, 0, 0, 65535, 6};
        hold_set = '{0, 2, 65535, 1, 4, 0, 6, 3, 0, 0, 65535, 1};
        req_ch.valid <= 1'b0;
        req_ch.item  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_DEBOUNCE_ON;
        cfg_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        calm = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: suspended, nothing sampled yet
        put_req(CMD_DEACTIVATE, 1'b0);
        put_req(CMD_ACTIVATE, 1'b1);
        put_req(CMD_UNUSED, 1'b1);
        put_req(CMD_TICK, 1'b0);
        put_req(CMD_TICK, 1'b1);
        put_req(CMD_TICK, 1'b1);
        put_req(CMD_ACTIVATE, 1'b0);
        put_req(CMD_DEACTIVATE, 1'b1);
        put_req(CMD_DEACTIVATE, 1'b0);
        put_req(CMD_TICK, 1'b0);
        put_req(CMD_ACTIVATE, 1'b0);
        put_req(CMD_TICK, 1'b1);

        // low counts as on, inverted output, debounce against hold-off
        set_regs(16'd2, 16'd3, 1'b0, 1'b1);
        put_req(CMD_TICK, 1'b1);
        put_req(CMD_TICK, 1'b0);
        put_req(CMD_TICK, 1'b0);
        put_req(CMD_TICK, 1'b0);
        put_req(CMD_TICK, 1'b1);
        put_req(CMD_TICK, 1'b0);
        put_req(CMD_TICK, 1'b0);
        put_req(CMD_TICK, 1'b0);
        put_req(CMD_UNUSED, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            deb  = deb_set[p];
            hold = hold_set[p];
            if (p == 8 || p == 9) begin
                deb  = $urandom_range(0, 8);
                hold = $urandom_range(0, 10);
            end
            set_regs(deb[CFG_WIDTH-1:0], hold[CFG_WIDTH-1:0], p[0], p[1]);
            calm = (p % 4 == 3);
            pin_traffic(deb, hold, PHASE_REQS);
            calm = 1'b0;
        end

        park_sender();
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("tb: %0d requests over %0d register settings, %0d results checked",
                 n_req, n_settings, checked);
        $display("tb: %0d on/off notifications seen, %0d still outstanding at the end",
                 notes, pending);
        if (faults == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
